// File: rtl/tkd_pkg.sv
// Package for the terminal key escape decoder: key codes, byte codes, decode functions.
package tkd_pkg;

    localparam int KIND_W = 4;
    localparam int BYTE_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KEY_CHAR   = 4'd0,
        KEY_ESC    = 4'd1,
        KEY_UP     = 4'd2,
        KEY_DOWN   = 4'd3,
        KEY_RIGHT  = 4'd4,
        KEY_LEFT   = 4'd5,
        KEY_HOME   = 4'd6,
        KEY_END    = 4'd7,
        KEY_DEL    = 4'd8,
        KEY_PGUP   = 4'd9,
        KEY_PGDN   = 4'd10,
        KEY_LSTART = 4'd11,
        KEY_LEND   = 4'd12
    } key_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_ONE   = 4'b0100,
        PH_DIGIT = 4'b1000
    } phase_t;

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t BYTE_ESC     = 8'h1B;
    localparam byte_t BYTE_LBRACK  = 8'h5B; // '['
    localparam byte_t BYTE_O       = 8'h4F; // 'O'
    localparam byte_t BYTE_TILDE   = 8'h7E; // '~'
    localparam byte_t BYTE_ZERO    = 8'h30; // '0'
    localparam byte_t BYTE_NINE    = 8'h39; // '9'
    localparam byte_t BYTE_ONE     = 8'h31;
    localparam byte_t BYTE_THREE   = 8'h33;
    localparam byte_t BYTE_FOUR    = 8'h34;
    localparam byte_t BYTE_FIVE    = 8'h35;
    localparam byte_t BYTE_SIX     = 8'h36;
    localparam byte_t BYTE_SEVEN   = 8'h37;
    localparam byte_t BYTE_EIGHT   = 8'h38;
    localparam byte_t BYTE_A       = 8'h41;
    localparam byte_t BYTE_B       = 8'h42;
    localparam byte_t BYTE_C       = 8'h43;
    localparam byte_t BYTE_D       = 8'h44;
    localparam byte_t BYTE_H       = 8'h48;
    localparam byte_t BYTE_F       = 8'h46;
    localparam byte_t BYTE_LC_H    = 8'h68;
    localparam byte_t BYTE_LC_J    = 8'h6A;
    localparam byte_t BYTE_LC_K    = 8'h6B;
    localparam byte_t BYTE_LC_L    = 8'h6C;
    localparam byte_t BYTE_DOLLAR  = 8'h24;

    function automatic key_kind_t plain_kind(input logic vim, input byte_t b);
        key_kind_t k;
        k = KEY_CHAR;
        if (vim) begin
            case (b)
                BYTE_LC_K:   k = KEY_UP;
                BYTE_LC_J:   k = KEY_DOWN;
                BYTE_LC_L:   k = KEY_RIGHT;
                BYTE_LC_H:   k = KEY_LEFT;
                BYTE_ZERO:   k = KEY_LSTART;
                BYTE_DOLLAR: k = KEY_LEND;
                default:     k = KEY_CHAR;
            endcase
        end
        return k;
    endfunction

    function automatic key_kind_t two_byte_kind(input byte_t b0, input byte_t b1);
        key_kind_t k;
        k = KEY_ESC;
        if (b0 == BYTE_LBRACK) begin
            case (b1)
                BYTE_A:  k = KEY_UP;
                BYTE_B:  k = KEY_DOWN;
                BYTE_C:  k = KEY_RIGHT;
                BYTE_D:  k = KEY_LEFT;
                BYTE_H:  k = KEY_HOME;
                BYTE_F:  k = KEY_END;
                default: k = KEY_ESC;
            endcase
        end else if (b0 == BYTE_O) begin
            if (b1 == BYTE_H) begin
                k = KEY_HOME;
            end else if (b1 == BYTE_F) begin
                k = KEY_END;
            end
        end
        return k;
    endfunction

    function automatic key_kind_t digit_kind(input byte_t d, input byte_t last);
        key_kind_t k;
        k = KEY_ESC;
        if (last == BYTE_TILDE) begin
            case (d)
                BYTE_ONE:   k = KEY_HOME;
                BYTE_THREE: k = KEY_DEL;
                BYTE_FOUR:  k = KEY_END;
                BYTE_FIVE:  k = KEY_PGUP;
                BYTE_SIX:   k = KEY_PGDN;
                BYTE_SEVEN: k = KEY_HOME;
                BYTE_EIGHT: k = KEY_END;
                default:    k = KEY_ESC;
            endcase
        end
        return k;
    endfunction

endpackage

// File: rtl/terminal_key_escape_decoder_unit.sv
// Terminal key escape decoder: turns input bytes and timeouts into key events.
//
// One input beat (a byte, or a timeout with s_func high) is taken every cycle
// while s_ready is high. A beat lands in an input register, is decoded against
// the escape-sequence state in one short combinational pass, and its key event
// (if any) lands in the result register, which drives m_valid. Throughput is
// one beat per cycle while results are taken, set by that single registered
// pass. A result held by m_ready low stalls the input register, and s_ready
// drops once both registers are full. ESC starts a sequence; ESC [ A/B/C/D/H/F,
// ESC [ digit ~ and ESC O H/F give the cursor, home, end, delete and page
// keys, any other complete sequence or a timeout inside one gives a lone
// escape key, and a timeout while idle gives nothing. Bytes that start no
// sequence pass through as plain characters (m_char_value holds the byte only
// for plain characters, else zero); with vim mode on, h j k l 0 $ become
// movement keys. Beats that open or extend a sequence give no result. The
// vim mode register is written with cfg_wr_en/cfg_wr_data while the block is
// idle (the user must ensure this; the block does not); it resets to off.
module terminal_key_escape_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [tkd_pkg::BYTE_W-1:0]    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tkd_pkg::KIND_W-1:0]    m_key_kind,
    output logic [tkd_pkg::BYTE_W-1:0]    m_char_value
);
    import tkd_pkg::*;

    // config
    logic vim_mode_reg;

    // input stage
    logic  in_vld_reg;
    logic  in_func_reg;
    byte_t in_byte_reg;

    // sequence state
    phase_t phase_reg, phase_next;
    byte_t  first_reg, first_next;
    byte_t  second_reg, second_next;

    // result stage
    logic      out_vld_reg;
    key_kind_t out_kind_reg;
    byte_t     out_char_reg;

    // decode outputs
    logic      emit;
    key_kind_t kind;
    byte_t     ch;

    logic advance;   // input-stage beat is consumed this cycle
    logic s_take;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vim_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            vim_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_data_byte;
        end
    end

    // Single-pass decode of the held beat against the current phase.
    always_comb begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        emit        = 1'b0;
        kind        = KEY_CHAR;
        ch          = '0;
        case (phase_reg)
            PH_ESC: begin
                if (in_func_reg) begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind       = KEY_ESC;
                end else begin
                    first_next = in_byte_reg;
                    phase_next = PH_ONE;
                end
            end
            PH_ONE: begin
                if (in_func_reg) begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind       = KEY_ESC;
                end else begin
                    second_next = in_byte_reg;
                    if (first_reg == BYTE_LBRACK &&
                        in_byte_reg inside {[BYTE_ZERO:BYTE_NINE]}) begin
                        phase_next = PH_DIGIT;
                    end else begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        kind       = two_byte_kind(first_reg, in_byte_reg);
                    end
                end
            end
            PH_DIGIT: begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                kind       = in_func_reg ? KEY_ESC : digit_kind(second_reg, in_byte_reg);
            end
            default: begin
                phase_next = PH_IDLE;
                if (!in_func_reg) begin
                    if (in_byte_reg == BYTE_ESC) begin
                        phase_next = PH_ESC;
                    end else begin
                        emit = 1'b1;
                        kind = plain_kind(vim_mode_reg, in_byte_reg);
                        ch   = (kind == KEY_CHAR) ? in_byte_reg : '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Result register: loads on an emitting beat, clears once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= emit;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_kind_reg <= kind;
            out_char_reg <= ch;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_key_kind   = out_kind_reg;
    assign m_char_value = out_char_reg;

    // A new result only ever comes from a held input beat.
    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(in_vld_reg))
        else $error("result appeared without an input beat");

    // Non-character keys carry a zero byte.
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_kind_reg != KEY_CHAR) |-> (out_char_reg == '0))
        else $error("char_value nonzero on a non-character key");

    // Digit phase only follows ESC [ and a digit.
    a_digit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DIGIT) |-> (first_reg == BYTE_LBRACK &&
            second_reg >= BYTE_ZERO && second_reg <= BYTE_NINE))
        else $error("digit phase without ESC [ digit prefix");

    // A held result is never overwritten while stalled.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> (out_vld_reg && $stable(out_kind_reg) &&
            $stable(out_char_reg)))
        else $error("stalled result was lost or changed");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the terminal key escape decoder: random byte streams and key checks.
module testbench;
    import tkd_pkg::*;

    // Run limit in clock cycles.
    localparam int LIMIT_CYCLES = 200000;
    // A key event shows once its beat has passed the input and result registers. Settle time leaves a wide margin.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long output stall, in cycles.
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_BEATS = 200;

    localparam byte_t CSI_FINALS [6] = '{BYTE_A, BYTE_B, BYTE_C, BYTE_D, BYTE_H, BYTE_F};
    localparam byte_t VIM_KEYS [6] = '{BYTE_LC_H, BYTE_LC_J, BYTE_LC_K, BYTE_LC_L,
                                       BYTE_ZERO, BYTE_DOLLAR};

    // Holds the expected key events. It tracks the decoder's sequence state and its
    // own copy of vim mode.
    class key_scoreboard;
        bit        vim = 1'b0;
        phase_t    ph = PH_IDLE;
        byte_t     seq_b0 = '0;
        byte_t     seq_b1 = '0;
        key_kind_t exp_kind [$];
        byte_t     exp_char [$];
        int        errors = 0;
        int        noted = 0;
        int        checked = 0;

        function int pending();
            return exp_kind.size();
        endfunction

        // Runs one accepted input beat through the sequence decoder.
        function void note_input(logic tmo, byte_t b);
            key_kind_t k;
            byte_t     c;
            bit        hit;
            k = KEY_ESC;
            c = '0;
            hit = 1'b0;
            noted++;
            case (ph)
                PH_ESC: begin
                    if (tmo) begin
                        hit = 1'b1;
                        ph = PH_IDLE;
                    end else begin
                        seq_b0 = b;
                        ph = PH_ONE;
                    end
                end
                PH_ONE: begin
                    if (tmo) begin
                        hit = 1'b1;
                        ph = PH_IDLE;
                    end else if (seq_b0 == BYTE_LBRACK && b >= BYTE_ZERO && b <= BYTE_NINE) begin
                        seq_b1 = b;
                        ph = PH_DIGIT;
                    end else begin
                        seq_b1 = b;
                        ph = PH_IDLE;
                        hit = 1'b1;
                        if (seq_b0 == BYTE_LBRACK) begin
                            case (b)
                                BYTE_A: k = KEY_UP;
                                BYTE_B: k = KEY_DOWN;
                                BYTE_C: k = KEY_RIGHT;
                                BYTE_D: k = KEY_LEFT;
                                BYTE_H: k = KEY_HOME;
                                BYTE_F: k = KEY_END;
                                default: k = KEY_ESC;
                            endcase
                        end else if (seq_b0 == BYTE_O && b == BYTE_H) begin
                            k = KEY_HOME;
                        end else if (seq_b0 == BYTE_O && b == BYTE_F) begin
                            k = KEY_END;
                        end
                    end
                end
                PH_DIGIT: begin
                    ph = PH_IDLE;
                    hit = 1'b1;
                    if (!tmo && b == BYTE_TILDE) begin
                        case (seq_b1)
                            BYTE_ONE, BYTE_SEVEN: k = KEY_HOME;
                            BYTE_THREE:           k = KEY_DEL;
                            BYTE_FOUR, BYTE_EIGHT: k = KEY_END;
                            BYTE_FIVE:            k = KEY_PGUP;
                            BYTE_SIX:             k = KEY_PGDN;
                            default:              k = KEY_ESC;
                        endcase
                    end
                end
                default: begin
                    ph = PH_IDLE;
                    if (!tmo && b == BYTE_ESC) begin
                        ph = PH_ESC;
                    end else if (!tmo) begin
                        hit = 1'b1;
                        k = KEY_CHAR;
                        if (vim) begin
                            case (b)
                                BYTE_LC_K:   k = KEY_UP;
                                BYTE_LC_J:   k = KEY_DOWN;
                                BYTE_LC_L:   k = KEY_RIGHT;
                                BYTE_LC_H:   k = KEY_LEFT;
                                BYTE_ZERO:   k = KEY_LSTART;
                                BYTE_DOLLAR: k = KEY_LEND;
                                default:     k = KEY_CHAR;
                            endcase
                        end
                        c = (k == KEY_CHAR) ? b : '0;
                    end
                end
            endcase
            if (hit) begin
                exp_kind.push_back(k);
                exp_char.push_back(c);
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] c);
            key_kind_t ek;
            byte_t     ec;
            checked++;
            if (exp_kind.size() == 0) begin
                $error("key event with none expected: key_kind %0d, char_value %0d", k, c);
                errors++;
                return;
            end
            ek = exp_kind.pop_front();
            ec = exp_char.pop_front();
            if (k !== ek) begin
                $error("key_kind: expected %0d, got %0d", ek, k);
                errors++;
            end
            if (c !== ec) begin
                $error("char_value: expected %0d, got %0d", ec, c);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_func;
    logic [BYTE_W-1:0] s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_key_kind;
    logic [BYTE_W-1:0] m_char_value;

    key_scoreboard sb = new;
    bit  bursts_on = 1'b1;  // random idle bursts on both sides
    bit  hold_req = 1'b0;   // asks the receiver for one long stall
    int  beats_sent = 0;
    int  cycles = 0;

    terminal_key_escape_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_kind  (m_key_kind),
        .m_char_value(m_char_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog. If a beat hangs or an expected key never shows up, the run ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor. Values are sampled at the edge, before that edge's updates land.
    // The result is checked before the input is noted, because a beat accepted on
    // this edge cannot produce its key event on the same edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_key_kind, m_char_value);
        end
        if (aresetn && s_valid && s_ready) begin
            sb.note_input(s_func, s_data_byte);
        end
    end

    // Receiver. It stalls in random bursts, or once for a long stretch when hold_req
    // is raised. Every pass of the loop starts just after a rising edge.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Sends one beat. It may first leave an idle gap with s_valid low. On return the beat
    // has just been accepted.
    task automatic send_beat(input logic tmo, input byte_t b);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= tmo;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_tmo();
        send_beat(1'b1, byte_t'($urandom_range(0, 255)));
    endtask

    // Stops sending and waits until every key event has arrived. Then it lets the
    // pipeline settle, so that a beat with no result is not still in flight.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes vim mode. The caller drains first, so the block is idle.
    task automatic set_vim(input bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.vim = v;
    endtask

    // Sends one random chunk of traffic. Some chunks are complete escape sequences
    // with listed or random finals. The rest are plain bytes, movement-key bytes,
    // idle timeouts and broken sequences.
    task automatic send_random_seq();
        int    sel;
        int    r;
        byte_t b;
        sel = $urandom_range(0, 99);
        r = $urandom_range(0, 9);
        b = byte_t'($urandom_range(0, 255));
        if (sel < 25) begin
            send_beat(1'b0, (b == BYTE_ESC) ? (BYTE_ESC ^ 8'h01) : b);
        end else if (sel < 35) begin
            send_beat(1'b0, VIM_KEYS[$urandom_range(0, 5)]);
        end else if (sel < 40) begin
            send_tmo();
        end else begin
            send_beat(1'b0, BYTE_ESC);
            if (sel < 58) begin
                // CSI with a letter final; sometimes a random final
                send_beat(1'b0, BYTE_LBRACK);
                send_beat(1'b0, (r < 8) ? CSI_FINALS[$urandom_range(0, 5)] : b);
            end else if (sel < 76) begin
                // CSI digit, normally closed by a tilde
                send_beat(1'b0, BYTE_LBRACK);
                send_beat(1'b0, BYTE_ZERO + byte_t'($urandom_range(0, 9)));
                if (r < 7) send_beat(1'b0, BYTE_TILDE);
                else if (r < 9) send_beat(1'b0, b);
                else send_tmo();
            end else if (sel < 84) begin
                send_beat(1'b0, BYTE_O);
                if (r < 4) send_beat(1'b0, BYTE_H);
                else if (r < 8) send_beat(1'b0, BYTE_F);
                else send_beat(1'b0, b);
            end else begin
                // broken: timeouts partway, or an unknown prefix
                case (r % 4)
                    0: send_tmo();
                    1: begin
                        send_beat(1'b0, b);
                        send_tmo();
                    end
                    2: begin
                        send_beat(1'b0, BYTE_LBRACK);
                        send_beat(1'b0, BYTE_ZERO + byte_t'($urandom_range(0, 9)));
                        send_tmo();
                    end
                    default: begin
                        send_beat(1'b0, b);
                        send_beat(1'b0, byte_t'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
    endtask

    initial begin
        int start;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_func      = 1'b0;
        s_data_byte = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats with vim mode off.
        set_vim(1'b0);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_tmo();                                  // timeout while idle: nothing
        send_beat(1'b0, BYTE_ESC);                   // lone escape
        send_tmo();
        send_beat(1'b0, BYTE_ESC);                   // page up
        send_beat(1'b0, BYTE_LBRACK);
        send_beat(1'b0, BYTE_FIVE);
        send_beat(1'b0, BYTE_TILDE);
        send_beat(1'b0, BYTE_ESC);                   // SS3 end
        send_beat(1'b0, BYTE_O);
        send_beat(1'b0, BYTE_F);
        send_beat(1'b0, BYTE_ESC);                   // digit 2 with tilde: lone escape
        send_beat(1'b0, BYTE_LBRACK);
        send_beat(1'b0, 8'h32);
        send_beat(1'b0, BYTE_TILDE);
        send_beat(1'b0, BYTE_ESC);                   // digit not closed by tilde
        send_beat(1'b0, BYTE_LBRACK);
        send_beat(1'b0, BYTE_SEVEN);
        send_beat(1'b0, 8'h71);
        send_beat(1'b0, BYTE_ESC);                   // ESC inside a sequence
        send_beat(1'b0, BYTE_ESC);
        send_beat(1'b0, BYTE_LBRACK);
        drain();

        // Directed beats with vim mode on: all six movement keys.
        set_vim(1'b1);
        foreach (VIM_KEYS[i]) send_beat(1'b0, VIM_KEYS[i]);
        drain();

        // Random part in four phases. Vim mode alternates between phases. The
        // second phase opens with a long output stall while beats keep coming,
        // and the last phase runs with no idling.
        for (int p = 0; p < 4; p++) begin
            set_vim(p % 2 == 0);
            bursts_on = (p != 3);
            if (p == 1) begin
                bursts_on = 1'b0;
                hold_req = 1'b1;
                repeat (20) send_beat(1'b0, byte_t'($urandom_range(32, 126)));
                bursts_on = 1'b1;
            end
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS) send_random_seq();
            drain();
        end

        $display("Sent %0d beats and checked %0d key events, with vim mode off and on.",
                 beats_sent, sb.checked);
        $display("Included idle bursts, one long output stall and a final phase at full rate.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
